/* rtl/core/rwje_pkg.sv */
// Shared constants and types for the RTT window jitter estimator.
package rwje_pkg;

   localparam int WINDOW        = 16;
   localparam int SAMPLE_W      = 16;
   localparam int COUNT_W       = 32;
   localparam int REPORT_PERIOD = 120 * 2;

   localparam int IDX_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam int N_W    = $clog2(WINDOW + 1);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int MOD_W  = $clog2(REPORT_PERIOD);

   typedef logic [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [N_W-1:0]    divisor;
   } div_req_type;

endpackage

/* rtl/core/rwje_cell.sv */
// One cell of the sample chain: holds one sample and passes it on when shifted.
module rwje_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  rwje_pkg::sample_type data_in,
   output rwje_pkg::sample_type data_out
);
   import rwje_pkg::*;

   sample_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

/* rtl/core/rwje_divider.sv */
// Restoring serial divider that yields one quotient bit per cycle.
module rwje_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  rwje_pkg::div_req_type       div_req,
   output logic                        done,
   output logic [rwje_pkg::SUM_W-1:0]  quotient
);
   import rwje_pkg::*;

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [N_W-1:0]    rem_ff, rem_in;
   logic [N_W-1:0]    div_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [N_W:0]      rem_sh;
   logic [N_W:0]      rem_sub;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      ge      = (rem_sh >= {1'b0, div_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         step_in = STEP_W'(SUM_W);
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         rem_in  = ge ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (div_req.start) begin
         div_ff <= div_req.divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/rtt_window_jitter_estimator_unit.sv */
// Top level of the RTT window jitter estimator.
//
// The req channel takes one round-trip-time sample per beat; the rsp channel
// returns one beat per sample with the jitter (largest minus smallest nonzero
// sample in the window), the truncated mean of the nonzero samples, the
// wrapping sample count and the report flag.
// The window is a chain of WINDOW cells. A new sample shifts in at the head
// and drops the oldest one. The chain then rotates once around while the
// tail is folded into min, max, sum and count. A serial divider then forms
// the mean. A new beat is taken only once the unit is idle again, after the
// result has been loaded into the rsp register, so samples do not overlap.
// Reset clears the window to zeros, the count and all handshake state.
// The rsp outputs form a register; a new sample is taken while a result
// waits, and the next result holds in the divider until rsp_ready frees it.
module rtt_window_jitter_estimator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [15:0]                    req_rtt_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [15:0]                    rsp_jitter,
   output logic [15:0]                    rsp_average,
   output logic [31:0]                    rsp_sample_count,
   output logic                           rsp_report_due
);
   import rwje_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_START = 2'd2;
   localparam logic [1:0] ST_DIV   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [MOD_W-1:0]   mod_ff, mod_in;
   logic               report_ff, report_in;
   sample_type         hi_ff, hi_in, lo_ff, lo_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [N_W-1:0]     n_ff, n_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        jitter_ff, average_ff;
   logic [31:0]        rsp_count_ff;
   logic               rsp_report_ff;

   logic               accept;
   logic               load_rsp;
   logic               shift_en;
   sample_type         head_in;
   sample_type         chain [WINDOW];
   sample_type         tail;
   div_req_type        div_req;
   logic               div_done;
   logic [SUM_W-1:0]   quotient;

   assign accept   = req_valid && req_ready;
   assign tail     = chain[WINDOW-1];
   assign shift_en = accept || (state_ff == ST_SCAN);
   assign head_in  = accept ? req_rtt_sample : tail;

   rwje_cell u_cell_head (
      .clock    (clock),
      .reset    (reset),
      .shift_en (shift_en),
      .data_in  (head_in),
      .data_out (chain[0])
   );

   for (genvar gi = 1; gi < WINDOW; gi++) begin : g_cell
      rwje_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .data_in  (chain[gi-1]),
         .data_out (chain[gi])
      );
   end

   assign div_req.start    = (state_ff == ST_START);
   assign div_req.dividend = sum_ff;
   assign div_req.divisor  = n_ff;

   rwje_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   assign load_rsp = div_done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      mod_in       = mod_ff;
      report_in    = report_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = count_ff + COUNT_W'(1);
               if (count_in == '0 || mod_ff == MOD_W'(REPORT_PERIOD - 1)) begin
                  mod_in = '0;
               end else begin
                  mod_in = mod_ff + MOD_W'(1);
               end
               report_in = (count_in == COUNT_W'(WINDOW)) || (mod_in == '0);
               hi_in     = '0;
               lo_in     = '0;
               sum_in    = '0;
               n_in      = '0;
               idx_in    = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail != '0) begin
               if (tail > hi_ff) begin
                  hi_in = tail;
               end
               if (lo_ff == '0 || tail < lo_ff) begin
                  lo_in = tail;
               end
               sum_in = sum_ff + SUM_W'(tail);
               n_in   = n_ff + N_W'(1);
            end
            if (idx_ff == IDX_W'(WINDOW - 1)) begin
               idx_in   = '0;
               state_in = ST_START;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         mod_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      report_ff <= report_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      sum_ff    <= sum_in;
      n_ff      <= n_in;
      if (load_rsp && state_ff == ST_DIV) begin
         jitter_ff     <= hi_ff - lo_ff;
         average_ff    <= (n_ff == '0) ? 16'd0 : quotient[15:0];
         rsp_count_ff  <= count_ff;
         rsp_report_ff <= report_ff;
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_jitter       = jitter_ff;
   assign rsp_average      = average_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_report_due   = rsp_report_ff;

`ifndef SYNTHESIS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while a sample is still in work");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("sample count did not advance by one");

   a_scan_idle : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> idx_ff == '0)
      else $error("scan index left nonzero outside a scan");

   a_avg_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_jitter != 16'd0 |-> rsp_average != 16'd0)
      else $error("zero average with a nonzero spread");
`endif

endmodule

/* tb/sv/rwje_checker.sv */
`timescale 1ns / 100ps
// Checker for the RTT window jitter estimator: predicts each result and compares it.
module rwje_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_rtt_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_jitter,
   input  logic [15:0] rsp_average,
   input  logic [31:0] rsp_sample_count,
   input  logic        rsp_report_due,
   output int          mismatches,
   output int          outstanding
);
   import rwje_pkg::*;

   localparam int PRED_DEPTH = 16;

   typedef struct packed {
      logic [15:0] jitter;
      logic [15:0] average;
      logic [31:0] sample_count;
      logic        report_due;
   } window_summary_type;

   sample_type         rtt_ring [WINDOW];
   int unsigned        ring_ptr;
   logic [31:0]        samples_taken;
   window_summary_type pred_buf [PRED_DEPTH];
   int unsigned        pred_wr;
   int unsigned        pred_rd;
   int                 error_total = 0;

   function automatic window_summary_type summarize_window(input sample_type rtt);
      window_summary_type summary;
      logic [15:0]        longest;
      logic [15:0]        shortest;
      logic [31:0]        total;
      int unsigned        filled;
      longest  = '0;
      shortest = '0;
      total    = '0;
      filled   = 0;
      ring_ptr = (ring_ptr + 1) % WINDOW;
      rtt_ring[ring_ptr] = rtt;
      samples_taken = samples_taken + 32'd1;
      foreach (rtt_ring[i]) begin
         if (rtt_ring[i] != '0) begin
            if (rtt_ring[i] > longest) longest = rtt_ring[i];
            if (shortest == '0 || rtt_ring[i] < shortest) shortest = rtt_ring[i];
            total  = total + 32'(rtt_ring[i]);
            filled = filled + 1;
         end
      end
      summary.jitter       = longest - shortest;
      summary.average      = (filled != 0) ? 16'(total / filled) : 16'd0;
      summary.sample_count = samples_taken;
      summary.report_due   = (samples_taken == 32'(WINDOW)) ||
                             (samples_taken % 32'(REPORT_PERIOD) == 32'd0);
      return summary;
   endfunction

   always @(posedge clock) begin
      window_summary_type want;
      if (reset) begin
         foreach (rtt_ring[i]) rtt_ring[i] = '0;
         ring_ptr      = 0;
         samples_taken = '0;
         pred_wr       = 0;
         pred_rd       = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pred_wr == pred_rd) begin
               $error("rsp beat with no result expected");
               error_total++;
            end else begin
               want    = pred_buf[pred_rd % PRED_DEPTH];
               pred_rd = pred_rd + 1;
               if (rsp_jitter !== want.jitter) begin
                  $error("jitter: expected %0d, got %0d", want.jitter, rsp_jitter);
                  error_total++;
               end
               if (rsp_average !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_average);
                  error_total++;
               end
               if (rsp_sample_count !== want.sample_count) begin
                  $error("sample_count: expected %0d, got %0d",
                         want.sample_count, rsp_sample_count);
                  error_total++;
               end
               if (rsp_report_due !== want.report_due) begin
                  $error("report_due: expected %0d, got %0d",
                         want.report_due, rsp_report_due);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (pred_wr - pred_rd == PRED_DEPTH) begin
               $error("too many req beats without a rsp beat");
               error_total++;
            end else begin
               pred_buf[pred_wr % PRED_DEPTH] = summarize_window(req_rtt_sample);
               pred_wr = pred_wr + 1;
            end
         end
      end
      mismatches  <= error_total;
      outstanding <= int'(pred_wr - pred_rd);
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, sample stimulus, rsp back-pressure and verdict.
module testbench;

   localparam int RANDOM_SAMPLES = 800;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int SETTLE_CYCLES  = 80;

   typedef enum int {
      MIX_FULL_RANGE,
      MIX_SMALL,
      MIX_NEAR_TOP,
      MIX_SPARSE,
      MIX_CONSTANT
   } sample_mix_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [15:0] req_rtt_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [15:0] rsp_jitter;
   logic [15:0] rsp_average;
   logic [31:0] rsp_sample_count;
   logic        rsp_report_due;
   int          mismatches;
   int          outstanding;
   int          cycle_count    = 0;
   logic        draining       = 1'b0;
   logic        no_idle        = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rtt_window_jitter_estimator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rtt_sample   (req_rtt_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_jitter       (rsp_jitter),
      .rsp_average      (rsp_average),
      .rsp_sample_count (rsp_sample_count),
      .rsp_report_due   (rsp_report_due)
   );

   rwje_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rtt_sample   (req_rtt_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_jitter       (rsp_jitter),
      .rsp_average      (rsp_average),
      .rsp_sample_count (rsp_sample_count),
      .rsp_report_due   (rsp_report_due),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   function automatic logic [15:0] draw_sample(input sample_mix_type mix,
                                               input logic [15:0] held);
      case (mix)
         MIX_SMALL:    return 16'($urandom_range(0, 15));
         MIX_NEAR_TOP: begin
            if ($urandom_range(0, 5) == 0) return 16'($urandom_range(0, 2));
            return 16'($urandom_range(65500, 65535));
         end
         MIX_SPARSE:   begin
            if ($urandom_range(0, 4) != 0) return 16'd0;
            return 16'($urandom);
         end
         MIX_CONSTANT: return held;
         default:      return 16'($urandom);
      endcase
   endfunction

   // Offers one sample beat; valid stays high into the next beat when no gap follows.
   task automatic send_rtt(input logic [15:0] rtt);
      int gap;
      gap = idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rtt_sample <= rtt;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int run_len;
      int stall_len;
      forever begin
         if (draining) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            case ($urandom_range(0, 19))
               0:       stall_len = $urandom_range(50, 200);
               1, 2, 3: stall_len = $urandom_range(4, 20);
               default: stall_len = $urandom_range(0, 3);
            endcase
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            if (stall_len != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall_len) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat (run_len) @(posedge clock);
         end
      end
   end

   initial begin
      logic [15:0]    directed [];
      sample_mix_type mix;
      logic [15:0]    held;
      int             burst;
      int             sent;
      directed = '{16'd0, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd32768,
                   16'd32767, 16'd65535, 16'd65535, 16'd1, 16'd2,
                   16'd0, 16'd100, 16'd65534, 16'h5555, 16'hAAAA,
                   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'd0, 16'd0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_rtt(directed[i]);
      sent = 0;
      while (sent < RANDOM_SAMPLES) begin
         mix     = sample_mix_type'($urandom_range(0, 4));
         held    = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
         no_idle = ($urandom_range(0, 3) == 0);
         burst   = $urandom_range(8, 40);
         repeat (burst) begin
            send_rtt(draw_sample(mix, held));
            sent++;
         end
      end
      req_valid <= 1'b0;
      draining  <= 1'b1;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/rwje_pkg.sv
rtl/core/rwje_cell.sv
rtl/core/rwje_divider.sv
rtl/core/rtt_window_jitter_estimator_unit.sv
tb/sv/rwje_checker.sv
tb/sv/testbench.sv
